[rtl/mhtq_pkg.sv]
// Shared constants, types and codes for the min-heap timer queue.
`default_nettype none

package mhtq_pkg;

  localparam int HEAP_DEPTH = 32;
  localparam int IDX_W      = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int CH_W       = IDX_W + 2;
  localparam int EXP_W      = 48;
  localparam int ID_W       = 16;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_FIRED = 2'd2,
    ST_DONE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [EXP_W-1:0] expiry;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef enum logic [1:0] {
    PICK_ITEM,
    PICK_LEFT,
    PICK_RIGHT
  } pick_t;

  typedef struct packed {
    logic l_ok;
    logic r_ok;
  } kid_ok_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CMP,
    S_PLACE,
    S_T_READ,
    S_T_TEST,
    S_D_LAST,
    S_D_CMP,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

[rtl/mhtq_if.sv]
// Request and response channel interfaces of the timer queue.
`default_nettype none

interface mhtq_req_if import mhtq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [EXP_W-1:0] expiry_ms;
  logic [EXP_W-1:0] now_ms;

  modport source(output valid, req_type, expiry_ms, now_ms, input ready);
  modport sink(input valid, req_type, expiry_ms, now_ms, output ready);
endinterface

interface mhtq_rsp_if import mhtq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [ID_W-1:0]  timer_id;
  logic [EXP_W-1:0] fired_expiry_ms;
  logic             last;

  modport source(output valid, status, timer_id, fired_expiry_ms, last, input ready);
  modport sink(input valid, status, timer_id, fired_expiry_ms, last, output ready);
endinterface

`default_nettype wire

[rtl/min_heap_timer_queue.sv]
// Top level: timer queue as a binary min-heap held in one synchronous memory.
//
// channel  dir  payload                                    transfer when
// req      in   req_type, expiry_ms, now_ms                req.valid && req.ready
// rsp      out  status, timer_id, fired_expiry_ms, last    rsp.valid && rsp.ready
//
// Add: one parent compare per level climbed (at most log2 of the depth), then the
// timer is placed; a full heap goes straight to the response. Tick: each fired timer
// is popped and the refilled root sinks; the pop that empties the heap skips the sink.
// Each compare round is one read-compare-write on the heap memory.
// Reset clears the fill count and the id counter; heap entries need no clearing.
// A stalled response holds the engine; a new request is taken once the final
// result sits in the output register.
`default_nettype none

module min_heap_timer_queue import mhtq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  mhtq_req_if.sink   req,
  mhtq_rsp_if.source rsp
);

  function automatic logic [CH_W-1:0] kid_l(input logic [IDX_W-1:0] p);
    return {1'b0, p, 1'b1};
  endfunction

  function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] d;
    d = p - 1'b1;
    return d >> 1;
  endfunction

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [ID_W-1:0]    next_id, next_id_next;
  logic [IDX_W-1:0]   pos, pos_next;
  entry_t             item, item_next;
  logic [EXP_W-1:0]   now_q, now_q_next;
  status_t            rsp_code, rsp_code_next;
  logic [ID_W-1:0]    rsp_tid, rsp_tid_next;

  entry_t             mem [HEAP_DEPTH];
  entry_t             rd_a;
  entry_t             rd_b;
  logic               rd_en_a;
  logic               rd_en_b;
  logic [IDX_W-1:0]   rd_addr_a;
  logic [IDX_W-1:0]   rd_addr_b;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  logic               out_valid;
  status_t            out_status;
  logic [ID_W-1:0]    out_id;
  logic [EXP_W-1:0]   out_exp;
  logic               out_last;
  logic               out_free;
  logic               ld;
  status_t            ld_status;
  logic [ID_W-1:0]    ld_id;
  logic [EXP_W-1:0]   ld_exp;
  logic               ld_last;

  entry_t             pk_item;
  entry_t             pk_left;
  kid_ok_t            pk_ok;
  pick_t              pk_sel;

  logic [CH_W-1:0]    cur_l;
  logic [CH_W-1:0]    cur_r;
  logic [IDX_W-1:0]   new_pos;
  logic [CH_W-1:0]    new_l;
  logic [CH_W-1:0]    new_r;
  logic [IDX_W-1:0]   up_par;
  logic               accept;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign out_free = !out_valid || rsp.ready;

  assign cur_l  = kid_l(pos);
  assign cur_r  = cur_l + 1'b1;
  assign new_l  = kid_l(new_pos);
  assign new_r  = new_l + 1'b1;
  assign up_par = parent_of(pos);

  always_comb begin
    new_pos = (pk_sel == PICK_RIGHT) ? cur_r[IDX_W-1:0] : cur_l[IDX_W-1:0];
  end

  // sift-up reuses the compare unit: new timer as left child against its parent
  always_comb begin
    if (state == S_UP_CMP) begin
      pk_item = rd_a;
      pk_left = item;
      pk_ok   = '{l_ok: 1'b1, r_ok: 1'b0};
    end else begin
      pk_item = item;
      pk_left = rd_a;
      pk_ok   = '{l_ok: (cur_l < CH_W'(count)), r_ok: (cur_r < CH_W'(count))};
    end
  end

  mhtq_pick u_pick (
    .item  (pk_item),
    .left  (pk_left),
    .right (rd_b),
    .ok    (pk_ok),
    .sel   (pk_sel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      next_id <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      next_id <= next_id_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    item     <= item_next;
    now_q    <= now_q_next;
    rsp_code <= rsp_code_next;
    rsp_tid  <= rsp_tid_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    next_id_next  = next_id;
    pos_next      = pos;
    item_next     = item;
    now_q_next    = now_q;
    rsp_code_next = rsp_code;
    rsp_tid_next  = rsp_tid;
    rd_en_a       = 1'b0;
    rd_en_b       = 1'b0;
    rd_addr_a     = '0;
    rd_addr_b     = '0;
    wr_en         = 1'b0;
    wr_addr       = pos;
    wr_data       = item;
    ld            = 1'b0;
    ld_status     = ST_DONE;
    ld_id         = '0;
    ld_exp        = '0;
    ld_last       = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_ADD) begin
            if (count == CNT_W'(HEAP_DEPTH)) begin
              rsp_code_next = ST_FULL;
              rsp_tid_next  = '0;
              state_next    = S_DONE;
            end else begin
              item_next     = '{expiry: req.expiry_ms, id: next_id};
              rsp_code_next = ST_ADDED;
              rsp_tid_next  = next_id;
              next_id_next  = next_id + 1'b1;
              pos_next      = count[IDX_W-1:0];
              count_next    = count + 1'b1;
              if (count == '0) begin
                state_next = S_PLACE;
              end else begin
                rd_en_a    = 1'b1;
                rd_addr_a  = parent_of(count[IDX_W-1:0]);
                state_next = S_UP_CMP;
              end
            end
          end else begin
            now_q_next    = req.now_ms;
            rsp_code_next = ST_DONE;
            rsp_tid_next  = '0;
            state_next    = S_T_READ;
          end
        end
      end

      S_UP_CMP: begin
        if (pk_sel == PICK_LEFT) begin
          // move the parent down into the hole and climb
          wr_en    = 1'b1;
          wr_data  = rd_a;
          pos_next = up_par;
          if (up_par == '0) begin
            state_next = S_PLACE;
          end else begin
            rd_en_a   = 1'b1;
            rd_addr_a = parent_of(up_par);
          end
        end else begin
          state_next = S_PLACE;
        end
      end

      S_PLACE: begin
        wr_en      = 1'b1;
        state_next = S_DONE;
      end

      S_T_READ: begin
        if (count == '0) begin
          state_next = S_DONE;
        end else begin
          rd_en_a    = 1'b1;
          rd_addr_a  = '0;
          state_next = S_T_TEST;
        end
      end

      S_T_TEST: begin
        if (rd_a.expiry > now_q) begin
          state_next = S_DONE;
        end else if (out_free) begin
          ld         = 1'b1;
          ld_status  = ST_FIRED;
          ld_id      = rd_a.id;
          ld_exp     = rd_a.expiry;
          ld_last    = 1'b0;
          count_next = count - 1'b1;
          if (count == CNT_W'(1)) begin
            state_next = S_DONE;
          end else begin
            rd_en_a    = 1'b1;
            rd_addr_a  = IDX_W'(count - 1'b1);
            state_next = S_D_LAST;
          end
        end
      end

      S_D_LAST: begin
        // last entry becomes the held item; fetch the root's children
        item_next  = rd_a;
        pos_next   = '0;
        rd_en_a    = (CH_W'(1) < CH_W'(count));
        rd_en_b    = (CH_W'(2) < CH_W'(count));
        rd_addr_a  = IDX_W'(1);
        rd_addr_b  = IDX_W'(2 % HEAP_DEPTH);
        state_next = S_D_CMP;
      end

      S_D_CMP: begin
        wr_en = 1'b1;
        case (pk_sel)
          PICK_LEFT, PICK_RIGHT: begin
            wr_data   = (pk_sel == PICK_RIGHT) ? rd_b : rd_a;
            pos_next  = new_pos;
            rd_en_a   = (new_l < CH_W'(count));
            rd_en_b   = (new_r < CH_W'(count));
            rd_addr_a = new_l[IDX_W-1:0];
            rd_addr_b = new_r[IDX_W-1:0];
          end
          default: begin
            state_next = S_T_READ;
          end
        endcase
      end

      S_DONE: begin
        if (out_free) begin
          ld         = 1'b1;
          ld_status  = rsp_code;
          ld_id      = rsp_tid;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en_a) begin
      rd_a <= mem[rd_addr_a];
    end
    if (rd_en_b) begin
      rd_b <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_status <= ld_status;
      out_id     <= ld_id;
      out_exp    <= ld_exp;
      out_last   <= ld_last;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.timer_id        = out_id;
  assign rsp.fired_expiry_ms = out_exp;
  assign rsp.last            = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(HEAP_DEPTH))
    else $error("heap fill count beyond depth");

  a_write_in_heap: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CNT_W'(wr_addr) < count))
    else $error("heap write outside the filled region");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_T_TEST && ld) |=> (count == CNT_W'($past(count) - 1'b1)))
    else $error("fired timer did not shrink the heap");

  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_FIRED) |-> !out_last)
    else $error("fired result marked last");

endmodule

`default_nettype wire

[rtl/mhtq_pick.sv]
// Heap order compare: picks the smallest of a held entry and up to two children.
`default_nettype none

module mhtq_pick import mhtq_pkg::*; (
  input  entry_t  item,
  input  entry_t  left,
  input  entry_t  right,
  input  kid_ok_t ok,
  output pick_t   sel
);

  // earlier expiry wins, equal expiry goes to the lower id
  function automatic logic precedes(input entry_t a, input entry_t b);
    logic lt;
    lt = (a.expiry < b.expiry) || ((a.expiry == b.expiry) && (a.id < b.id));
    return lt;
  endfunction

  logic l_item;
  logic r_item;
  logic r_left;

  // all three compares run side by side
  assign l_item = ok.l_ok && precedes(left, item);
  assign r_item = ok.r_ok && precedes(right, item);
  assign r_left = ok.r_ok && precedes(right, left);

  always_comb begin
    if (l_item) begin
      sel = r_left ? PICK_RIGHT : PICK_LEFT;
    end else begin
      sel = r_item ? PICK_RIGHT : PICK_ITEM;
    end
  end

endmodule

`default_nettype wire
